/* hw/rtl/ra_pkg.sv */
// Shared constants, types and codes for the room allocator.
`timescale 1ns / 1ps

package ra_pkg;

   // Built room count and the largest count a request may scan.
   localparam int NUM_ROOMS  = 16;
   localparam int ROOM_LIMIT = (NUM_ROOMS < 16) ? NUM_ROOMS : 16;

   // Field widths.
   localparam int ROOM_W = 4;
   localparam int CNT_W  = 5;
   localparam int TIME_W = 32;
   localparam int FIN_W  = 48;
   localparam int USES_W = 16;
   localparam int WORD_W = USES_W + FIN_W;

   localparam logic [FIN_W-1:0]  FINISH_MAX = '1;
   localparam logic [USES_W-1:0] USES_MAX   = '1;

   // Configuration port.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [0:0]       REG_ROOM_COUNT = 1'b0;
   localparam logic [CNT_W-1:0] ROOM_COUNT_RST = CNT_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } ra_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic              load;
      logic              issue;
      logic [ROOM_W-1:0] rd_addr;
      logic              commit;
   } ra_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [CNT_W-1:0] active_rooms;
      logic             out_busy;
   } ra_stat_type;

endpackage

/* hw/rtl/ra_req_if.sv */
// Request channel: valid/ready handshake with start and end times.
`timescale 1ns / 1ps

interface ra_req_if
   import ra_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] start_time;
   logic [TIME_W-1:0] end_time;

   modport source (output valid, output start_time, output end_time, input ready);
   modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

/* hw/rtl/ra_rsp_if.sv */
// Result channel: valid/ready handshake with the allocation result.
`timescale 1ns / 1ps

interface ra_rsp_if
   import ra_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [ROOM_W-1:0] assigned_room;
   logic [FIN_W-1:0]  finish_time;
   logic              was_delayed;
   logic [ROOM_W-1:0] best_room;

   modport source (output valid, output assigned_room, output finish_time,
                   output was_delayed, output best_room, input ready);
   modport sink   (input valid, input assigned_room, input finish_time,
                   input was_delayed, input best_room, output ready);
endinterface

/* hw/rtl/ra_ctrl.sv */
// Sequencer: accepts a request, walks the room table, then commits.
`timescale 1ns / 1ps

module ra_ctrl
   import ra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ra_stat_type stat,
   output ra_cmd_type  cmd
);

   ra_state_type     state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] scan_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   assign scan_next = scan_ff + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.issue   = 1'b0;
      cmd.rd_addr = scan_ff[ROOM_W-1:0];
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            scan_in   = scan_next;
            if (scan_next == stat.active_rooms) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read entry is evaluated here
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/ra_dp.sv */
// Datapath: room table, scan compare, commit arithmetic, CSR and result register.
`timescale 1ns / 1ps

module ra_dp
   import ra_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ra_cmd_type        cmd,
   output ra_stat_type       stat,
   input  logic [TIME_W-1:0] req_start_time,
   input  logic [TIME_W-1:0] req_end_time,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ROOM_W-1:0] rsp_assigned_room,
   output logic [FIN_W-1:0]  rsp_finish_time,
   output logic              rsp_was_delayed,
   output logic [ROOM_W-1:0] rsp_best_room,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // room table: {uses, finish} per room, valid bit means written since reset
   logic [WORD_W-1:0]    room_mem [NUM_ROOMS];
   logic [NUM_ROOMS-1:0] room_vld_ff;

   logic [CNT_W-1:0]  room_count_ff;
   logic [TIME_W-1:0] start_ff, end_ff, dur_ff;

   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_hit_ff, rd_vld_ff;
   logic [ROOM_W-1:0] rd_idx_ff;

   logic              found_ff;
   logic [ROOM_W-1:0] free_room_ff, min_room_ff;
   logic [USES_W-1:0] free_uses_ff, min_uses_ff;
   logic [FIN_W-1:0]  min_fin_ff;

   logic [ROOM_W-1:0] top_room_ff;
   logic [USES_W-1:0] top_uses_ff;

   logic              rsp_valid_ff;
   logic [ROOM_W-1:0] rsp_room_ff, rsp_best_ff;
   logic [FIN_W-1:0]  rsp_fin_ff;
   logic              rsp_delay_ff;

   logic [FIN_W-1:0]  ent_fin;
   logic [USES_W-1:0] ent_uses;
   logic [FIN_W:0]    fin_sum;
   logic [FIN_W-1:0]  fin_new;
   logic [ROOM_W-1:0] sel_room;
   logic [USES_W-1:0] sel_uses, uses_new;
   logic              top_take;
   logic              csr_wr;

   // ---------------- configuration
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ROOM_COUNT) ?
                       CSR_DW'(room_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         room_count_ff <= ROOM_COUNT_RST;
      end else if (csr_wr && csr_paddr[2] == REG_ROOM_COUNT) begin
         room_count_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   always_comb begin
      if (room_count_ff == '0) begin
         stat.active_rooms = CNT_W'(1);
      end else if (room_count_ff > CNT_W'(ROOM_LIMIT)) begin
         stat.active_rooms = CNT_W'(ROOM_LIMIT);
      end else begin
         stat.active_rooms = room_count_ff;
      end
      stat.out_busy = rsp_valid_ff & ~rsp_ready;
   end

   // ---------------- request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         start_ff <= req_start_time;
         end_ff   <= req_end_time;
         dur_ff   <= (req_end_time > req_start_time) ?
                     req_end_time - req_start_time : '0;
      end
   end

   // ---------------- table read, registered
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_word_ff <= room_mem[cmd.rd_addr];
         rd_idx_ff  <= cmd.rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         rd_hit_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         rd_hit_ff <= room_vld_ff[cmd.rd_addr];
      end
   end

   assign ent_fin  = rd_hit_ff ? rd_word_ff[FIN_W-1:0] : '0;
   assign ent_uses = rd_hit_ff ? rd_word_ff[WORD_W-1:FIN_W] : '0;

   // ---------------- scan: first free room, earliest finish
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (!found_ff && ent_fin <= FIN_W'(start_ff)) begin
            found_ff     <= 1'b1;
            free_room_ff <= rd_idx_ff;
            free_uses_ff <= ent_uses;
         end
         // strict less-than keeps the lower index on ties
         if (rd_idx_ff == '0 || ent_fin < min_fin_ff) begin
            min_room_ff <= rd_idx_ff;
            min_fin_ff  <= ent_fin;
            min_uses_ff <= ent_uses;
         end
      end
   end

   // ---------------- commit arithmetic
   assign sel_room = found_ff ? free_room_ff : min_room_ff;
   assign sel_uses = found_ff ? free_uses_ff : min_uses_ff;
   assign fin_sum  = {1'b0, min_fin_ff} + (FIN_W + 1)'(dur_ff);

   always_comb begin
      if (found_ff) begin
         fin_new = FIN_W'(end_ff);
      end else if (fin_sum[FIN_W]) begin
         fin_new = FINISH_MAX;
      end else begin
         fin_new = fin_sum[FIN_W-1:0];
      end
   end

   assign uses_new = (sel_uses == USES_MAX) ? sel_uses : sel_uses + USES_W'(1);
   assign top_take = (uses_new > top_uses_ff) ||
                     (uses_new == top_uses_ff && sel_room < top_room_ff);

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         room_mem[sel_room] <= {uses_new, fin_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         room_vld_ff <= '0;
         top_room_ff <= '0;
         top_uses_ff <= '0;
      end else if (cmd.commit) begin
         room_vld_ff[sel_room] <= 1'b1;
         if (top_take) begin
            top_room_ff <= sel_room;
            top_uses_ff <= uses_new;
         end
      end
   end

   // ---------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_room_ff  <= sel_room;
         rsp_fin_ff   <= fin_new;
         rsp_delay_ff <= ~found_ff;
         rsp_best_ff  <= top_take ? sel_room : top_room_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_assigned_room = rsp_room_ff;
   assign rsp_finish_time   = rsp_fin_ff;
   assign rsp_was_delayed   = rsp_delay_ff;
   assign rsp_best_room     = rsp_best_ff;

endmodule

/* hw/rtl/room_allocator_with_delay.sv */
// Top level of the meeting-room allocator: sequencer, datapath and channel wiring.
`timescale 1ns / 1ps

// Meeting-room allocator. Each request transaction (start_time, end_time),
// given in non-decreasing start order, is placed in the lowest-numbered
// active room that is free at start_time; if none is free it waits for the
// room that finishes earliest (lower index on ties) and that room's finish
// time grows by the request's duration, saturating at 2^48-1. One result
// transaction follows each request: the room, its new finish time, a delay
// flag and the most-booked room so far (lower index on ties; use counts
// saturate at 65535). The result is registered by the commit that ends
// each request: the room table is read one entry per cycle through its
// single read port for each of the N active rooms, the last entry read is
// compared in a drain state, and the commit writes the table back. The
// commit stretches while the previous result is still held in the output
// register by a stalled receiver. One request is in work at a time; the
// next is accepted right after the commit, while its result waits in the
// output register. room_count (CSR at byte address 0, bits [4:0], reset 16)
// sets the active rooms; zero acts as one. Rooms beyond it keep their state.
// Write it only while no request is in work. The room table comes up all
// zero after reset with no clearing pass.
module room_allocator_with_delay
   import ra_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ra_req_if.sink            req_chan,
   ra_rsp_if.source          rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   ra_cmd_type  cmd;
   ra_stat_type stat;

   // sequencer: owns the handshake on the request side and the scan counter
   ra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: table, compares, commit math, result register and CSR
   ra_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_start_time    (req_chan.start_time),
      .req_end_time      (req_chan.end_time),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_assigned_room (rsp_chan.assigned_room),
      .rsp_finish_time   (rsp_chan.finish_time),
      .rsp_was_delayed   (rsp_chan.was_delayed),
      .rsp_best_room     (rsp_chan.best_room),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

endmodule

/* hw/rtl/ra_checker.sv */
// Port-level checks for the room allocator and their bind to the top level.
`timescale 1ns / 1ps

module ra_checker
   import ra_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ROOM_W-1:0] rsp_assigned_room,
   input logic [FIN_W-1:0]  rsp_finish_time,
   input logic              rsp_was_delayed,
   input logic [ROOM_W-1:0] rsp_best_room
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_assigned_room) &&
      $stable(rsp_finish_time) && $stable(rsp_was_delayed) && $stable(rsp_best_room))
      else $error("result changed while stalled");

   // one request at a time: busy right after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in work");

   // an undelayed booking finishes at its 32-bit end time
   a_free_fin_narrow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_delayed |-> rsp_finish_time[FIN_W-1:TIME_W] == '0)
      else $error("free-room finish time wider than end time");

   // reset empties the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind room_allocator_with_delay ra_checker u_ra_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_assigned_room (rsp_chan.assigned_room),
   .rsp_finish_time   (rsp_chan.finish_time),
   .rsp_was_delayed   (rsp_chan.was_delayed),
   .rsp_best_room     (rsp_chan.best_room)
);

/* tb/room_allocator_with_delay_tb.sv */
// Self-checking testbench for the meeting-room allocator: directed table, random bookings, long waits.
`timescale 1ns / 1ps

// Every booking transaction that the allocator accepts goes through an
// in-bench model of the room table. The model keeps its own finish times,
// use counts, lead room and room count. Each result transaction is checked
// field by field against the oldest predicted booking.
// Run order:
//   - directed table: reset values, extreme times, zero and inverted
//     durations, a room count of zero (acting as one), tie breaks, saturated
//     room count, starts out of order
//   - random phases: mostly well-formed booking streams at about unit load
//     with random content, plus out-of-order starts, inverted ends and
//     full-range noise, walked through several room counts and idle patterns
//   - long-wait burst: one room, full-length waits that push the finish
//     time well past 32 bits
module room_allocator_with_delay_tb;
   import ra_pkg::*;

   typedef struct packed {
      logic [ROOM_W-1:0] assigned_room;
      logic [FIN_W-1:0]  finish_time;
      logic              was_delayed;
      logic [ROOM_W-1:0] best_room;
   } booking_type;

   typedef enum logic {ROW_CFG, ROW_REQ} row_kind_type;

   // One line of the directed table. ROW_CFG rows use only rooms; ROW_REQ
   // rows use the times, and carry a hand-worked result when typed is set.
   typedef struct packed {
      row_kind_type      kind;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [CNT_W-1:0]  rooms;
      logic              typed;
      booking_type       result;
   } plan_row_type;

   localparam logic [CSR_AW-1:0] ROOM_COUNT_ADDR = CSR_AW'(4 * REG_ROOM_COUNT);
   localparam logic [32:0]       TIME_TOP        = 33'hFFFF_FFFF;
   localparam int                LONG_WAITS      = 32;

   localparam int PLAN_LEN = 21;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // fresh table: lowest free rooms in turn
      '{ROW_REQ, 32'd0, 32'd10, 5'd0, 1'b1, '{4'd0, 48'd10, 1'b0, 4'd0}},
      '{ROW_REQ, 32'd0, 32'hFFFF_FFFF, 5'd0, 1'b1, '{4'd1, 48'hFFFF_FFFF, 1'b0, 4'd0}},
      // end equal to start, then end before start: finish is the end as given
      '{ROW_REQ, 32'd3, 32'd3, 5'd0, 1'b1, '{4'd2, 48'd3, 1'b0, 4'd0}},
      '{ROW_REQ, 32'd3, 32'd2, 5'd0, 1'b1, '{4'd2, 48'd2, 1'b0, 4'd2}},
      // room count zero acts as one room
      '{ROW_CFG, 32'd0, 32'd0, 5'd0, 1'b0, '0},
      '{ROW_REQ, 32'd4, 32'd20, 5'd0, 1'b1, '{4'd0, 48'd26, 1'b1, 4'd0}},
      // delayed with zero duration leaves the finish time alone
      '{ROW_REQ, 32'd4, 32'd4, 5'd0, 1'b1, '{4'd0, 48'd26, 1'b1, 4'd0}},
      '{ROW_REQ, 32'd30, 32'd31, 5'd0, 1'b1, '{4'd0, 48'd31, 1'b0, 4'd0}},
      '{ROW_CFG, 32'd0, 32'd0, 5'd2, 1'b0, '0},
      '{ROW_REQ, 32'd31, 32'd40, 5'd0, 1'b0, '0},
      '{ROW_REQ, 32'd31, 32'd50, 5'd0, 1'b0, '0},
      // oversized count clamps to the built rooms
      '{ROW_CFG, 32'd0, 32'd0, 5'd31, 1'b0, '0},
      '{ROW_REQ, 32'd35, 32'd36, 5'd0, 1'b0, '0},
      '{ROW_REQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b0, '0},
      // rooms 0 and 1 now tie on finish time: lower index wins, finish passes 32 bits
      '{ROW_CFG, 32'd0, 32'd0, 5'd2, 1'b0, '0},
      '{ROW_REQ, 32'd0, 32'd5, 5'd0, 1'b0, '0},
      '{ROW_REQ, 32'h10, 32'h20, 5'd0, 1'b0, '0},
      '{ROW_CFG, 32'd0, 32'd0, 5'd16, 1'b0, '0},
      '{ROW_REQ, 32'd100, 32'd200, 5'd0, 1'b0, '0},
      // start out of order
      '{ROW_REQ, 32'd0, 32'd1, 5'd0, 1'b0, '0},
      '{ROW_REQ, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 5'd0, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   ra_req_if req_chan ();
   ra_rsp_if rsp_chan ();

   room_allocator_with_delay dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Model of the room table.
   logic [FIN_W-1:0]  finish_table [NUM_ROOMS];
   logic [USES_W-1:0] uses_table [NUM_ROOMS];
   logic [ROOM_W-1:0] lead_room;
   logic [USES_W-1:0] lead_uses;
   logic [CNT_W-1:0]  rooms_setting;

   booking_type bookings_due [$];
   logic [31:0] book_time;     // running start time of the well-formed stream
   int          gap_pct;       // sender idle chance per cycle, in percent
   int          stall_pct;     // receiver stall chance per cycle, in percent
   int          mismatches;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_rooms();
      if (rooms_setting == 0)
         return 1;
      if (rooms_setting > ROOM_LIMIT)
         return ROOM_LIMIT;
      return rooms_setting;
   endfunction

   // Places one booking in the model and returns the result it must produce.
   function automatic booking_type book_room(input logic [TIME_W-1:0] s,
                                             input logic [TIME_W-1:0] e);
      booking_type      r;
      logic [FIN_W-1:0] dur;
      logic [FIN_W-1:0] fin;
      int               n;
      int               pick;
      bit               found;
      n = active_rooms();
      dur = (e > s) ? FIN_W'(e - s) : '0;
      found = 1'b0;
      pick = 0;
      for (int i = 0; i < n; i++) begin
         if (!found && finish_table[i] <= FIN_W'(s)) begin
            pick = i;
            found = 1'b1;
         end
      end
      if (found) begin
         fin = FIN_W'(e);
      end else begin
         // earliest finish, strict compare keeps the lower index on ties
         for (int i = 1; i < n; i++) begin
            if (finish_table[i] < finish_table[pick])
               pick = i;
         end
         fin = (dur > FINISH_MAX - finish_table[pick]) ? FINISH_MAX
                                                       : finish_table[pick] + dur;
      end
      finish_table[pick] = fin;
      if (uses_table[pick] != USES_MAX)
         uses_table[pick]++;
      if (uses_table[pick] > lead_uses ||
          (uses_table[pick] == lead_uses && pick < lead_room)) begin
         lead_uses = uses_table[pick];
         lead_room = ROOM_W'(pick);
      end
      r.assigned_room = ROOM_W'(pick);
      r.finish_time   = fin;
      r.was_delayed   = !found;
      r.best_room     = lead_room;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Drives one booking transaction; the model sees it at the accepting edge.
   task automatic send_booking(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                               input bit typed, input booking_type typed_res);
      booking_type due;
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.start_time <= s;
      req_chan.end_time   <= e;
      do @(posedge clock); while (!req_chan.ready);
      due = book_room(s, e);
      bookings_due.push_back(typed ? typed_res : due);
   endtask

   // Every booking yields a result, so an empty queue means the block is idle.
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (bookings_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic read_rooms(input logic [CNT_W-1:0] want);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ROOM_COUNT_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("room_count", 64'(want), 64'(csr_prdata[CNT_W-1:0]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Upper data bits are junk on purpose; only the low five bits count.
   task automatic write_rooms(input logic [CNT_W-1:0] value);
      logic [CSR_DW-1:0] word;
      word = $urandom();
      word[CNT_W-1:0] = value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ROOM_COUNT_ADDR;
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rooms_setting = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      read_rooms(value);
   endtask

   // Random bookings under one room count and one idle pattern. Durations
   // scale with the room count so the load sits near one: rooms free up
   // about as often as requests have to wait.
   task automatic run_phase(input int items, input int gap, input int stall,
                            input logic [CNT_W-1:0] rooms, input bit far);
      logic [32:0] s;
      logic [32:0] e;
      int          span;
      int          pick;
      wait_idle();
      gap_pct   = gap;
      stall_pct = stall;
      write_rooms(rooms);
      span = 7 * active_rooms();
      // start past the backlog so the phase opens with free rooms
      if (far) begin
         book_time = 32'hFFFF_F000;
      end else begin
         for (int i = 0; i < active_rooms(); i++) begin
            if (finish_table[i] > FIN_W'(book_time) && finish_table[i] <= FIN_W'(TIME_TOP))
               book_time = finish_table[i][31:0];
         end
      end
      repeat (items) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            // well-formed: non-decreasing start, end after start
            s = 33'(book_time) + 33'($urandom_range(8));
            s = (s > TIME_TOP) ? TIME_TOP : s;
            book_time = s[31:0];
            e = s + 33'($urandom_range(span, 1));
         end else if (pick < 92) begin
            // start behind the stream
            s = 33'(book_time) - 33'($urandom_range(50));
            if (s[32])
               s = '0;
            e = s + 33'($urandom_range(span, 1));
         end else if (pick < 98) begin
            // end at or before start
            s = 33'(book_time);
            e = s - 33'($urandom_range(20));
            if (e[32])
               e = '0;
         end else begin
            s = 33'($urandom());
            e = 33'($urandom());
         end
         e = (e > TIME_TOP) ? TIME_TOP : e;
         send_booking(s[31:0], e[31:0], 1'b0, '0);
      end
   endtask

   // Result side: random ready, checks on every accepted transaction.
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : result_check
      booking_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (bookings_due.size() == 0) begin
            $error("result transaction with none expected: room %0d finish %0d",
                   rsp_chan.assigned_room, rsp_chan.finish_time);
            mismatches++;
         end else begin
            want = bookings_due.pop_front();
            check_field("assigned_room", 64'(want.assigned_room), 64'(rsp_chan.assigned_room));
            check_field("finish_time", 64'(want.finish_time), 64'(rsp_chan.finish_time));
            check_field("was_delayed", 64'(want.was_delayed), 64'(rsp_chan.was_delayed));
            check_field("best_room", 64'(want.best_room), 64'(rsp_chan.best_room));
         end
      end
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.start_time = '0;
      req_chan.end_time   = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      mismatches          = 0;
      gap_pct             = 0;
      stall_pct           = 31;
      book_time           = '0;
      foreach (finish_table[i]) begin
         finish_table[i] = '0;
         uses_table[i]   = '0;
      end
      lead_room     = '0;
      lead_uses     = '0;
      rooms_setting = ROOM_COUNT_RST;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      read_rooms(ROOM_COUNT_RST);

      // directed table
      foreach (PLAN[k]) begin
         if (PLAN[k].kind == ROW_CFG) begin
            wait_idle();
            write_rooms(PLAN[k].rooms);
         end else begin
            send_booking(PLAN[k].start_time, PLAN[k].end_time, PLAN[k].typed, PLAN[k].result);
         end
      end

      // random phases: room counts hit zero, one, the build size and the top code
      run_phase(240, 0, 0, 5'd16, 1'b0);
      run_phase(240, 61, 0, 5'd1, 1'b0);
      run_phase(240, 0, 61, 5'd0, 1'b0);
      run_phase(240, 31, 31, 5'd31, 1'b0);
      run_phase(240, 0, 0, 5'd5, 1'b0);
      run_phase(240, 61, 0, CNT_W'($urandom_range(15, 2)), 1'b0);
      run_phase(240, 0, 61, 5'd17, 1'b0);
      run_phase(240, 31, 31, CNT_W'($urandom_range(31)), 1'b1);

      // Long waits: one room, every booking waits a full 2^32-1, so the
      // finish time climbs far past 32 bits.
      wait_idle();
      gap_pct   = 0;
      stall_pct = 0;
      write_rooms(5'd1);
      repeat (LONG_WAITS)
         send_booking('0, '1, 1'b0, '0);

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("room_allocator_with_delay_tb passed");
      else
         $display("room_allocator_with_delay_tb failed");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #(2_000_000);
      $display("room_allocator_with_delay_tb failed");
      $finish;
   end

endmodule
